### rtl/sfd_pkg.sv
// shared constants and types for the sync frame decoder with crc16 check
// no dependencies; used by sync_frame_decoder_crc16_top
package sfd_pkg;

  // framing bytes
  localparam logic [7:0] SYNC_FIRST  = 8'hEB;
  localparam logic [7:0] SYNC_SECOND = 8'h90;
  localparam logic [7:0] TAIL_BYTE   = 8'hED;

  // crc16-ccitt, msb first, no final xor
  localparam logic [15:0] CRC_POLY = 16'h1021;
  localparam logic [15:0] CRC_INIT = 16'hFFFF;

  // result status codes
  localparam logic [1:0] STATUS_NONE   = 2'd0;
  localparam logic [1:0] STATUS_REJECT = 2'd1;
  localparam logic [1:0] STATUS_DATA   = 2'd2;

  // frame positions before the payload
  localparam int unsigned POS_SYNC1   = 0;
  localparam int unsigned POS_SYNC2   = 1;
  localparam int unsigned POS_MSG_ID  = 2;
  localparam int unsigned POS_LENGTH  = 3;
  localparam int unsigned POS_PAYLOAD = 4;

  // control sequencer, one-hot
  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,  // waiting for a byte
    ST_CRC  = 4'b0010,  // shifting one payload byte through the crc
    ST_READ = 4'b0100,  // payload memory read in flight
    ST_OUT  = 4'b1000   // result held on the output
  } state_t;

endpackage

### rtl/sync_frame_decoder_crc16_top.sv
// sync frame decoder: sync hunt, length/tail/crc16 check, payload readout
// depends on sfd_pkg (constants, state type)
//
// throughput: a header, crc or tail byte is taken directly while idle; a data byte
// is accepted and then shifted bit by bit through the bit-serial crc, with in_stall high.
// a reject result is shown the cycle after the causing byte; a good frame
// gives its results one by one (payload memory read, then output, held while out_stall).
// reset (synchronous, rst_n low): hunt restarts at the first sync byte,
// crc = 0xffff, no result pending; the payload memory is not cleared
module sync_frame_decoder_crc16_top #(
  parameter int unsigned PAYLOAD_BYTES = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  // input channel
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_rx_byte,
  // result channel
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] out_status,
  output logic [7:0] out_message_id,
  output logic [7:0] out_payload_byte,
  output logic [5:0] out_byte_index,
  output logic       out_last
);

  // data bytes are covered by the crc, the last two carry the crc itself
  localparam int unsigned DATA_BYTES = PAYLOAD_BYTES - 2;
  localparam int unsigned POS_TAIL   = sfd_pkg::POS_PAYLOAD + PAYLOAD_BYTES;
  localparam int unsigned POS_W      = $clog2(POS_TAIL + 1);
  localparam int unsigned IDX_W      = $clog2(DATA_BYTES);
  localparam logic [7:0]  LEN_BYTE   = 8'(PAYLOAD_BYTES);

  localparam logic [POS_W-1:0] P_SYNC1   = POS_W'(sfd_pkg::POS_SYNC1);
  localparam logic [POS_W-1:0] P_SYNC2   = POS_W'(sfd_pkg::POS_SYNC2);
  localparam logic [POS_W-1:0] P_MSG_ID  = POS_W'(sfd_pkg::POS_MSG_ID);
  localparam logic [POS_W-1:0] P_LENGTH  = POS_W'(sfd_pkg::POS_LENGTH);
  localparam logic [POS_W-1:0] P_PAYLOAD = POS_W'(sfd_pkg::POS_PAYLOAD);
  localparam logic [POS_W-1:0] P_TAIL    = POS_W'(POS_TAIL);
  localparam logic [POS_W-1:0] P_DATA    = POS_W'(DATA_BYTES);
  localparam logic [POS_W-1:0] P_CRC_HI  = POS_W'(DATA_BYTES + 1);
  localparam logic [POS_W-1:0] P_ONE     = POS_W'(1);
  localparam logic [IDX_W-1:0] IDX_LAST  = IDX_W'(DATA_BYTES - 1);
  localparam logic [IDX_W-1:0] IDX_ONE   = IDX_W'(1);

  // control registers
  sfd_pkg::state_t  state_r, state_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [7:0]       msg_id_r, msg_id_nxt;
  logic [15:0]      crc_r, crc_nxt;
  logic [2:0]       bit_cnt_r, bit_cnt_nxt;
  logic [IDX_W-1:0] rd_idx_r, rd_idx_nxt;
  logic             err_r, err_nxt;

  // payload registers
  logic [7:0]       shift_r, shift_nxt;
  logic [7:0]       crc_lo_r, crc_lo_nxt;
  logic [7:0]       crc_hi_r, crc_hi_nxt;
  logic [7:0]       rd_data_r;

  // payload memory, data bytes only; the crc bytes sit in crc_lo_r/crc_hi_r
  logic [7:0]       payload_mem [DATA_BYTES];

  logic             in_fire;
  logic             out_fire;
  logic [POS_W-1:0] data_pos;   // position within the payload
  logic             crc_fb;     // feedback bit of the serial crc

  assign in_stall = (state_r != sfd_pkg::ST_IDLE);
  assign in_fire  = in_valid && !in_stall;
  assign out_fire = out_valid && !out_stall;
  assign data_pos = pos_r - P_PAYLOAD;
  assign crc_fb   = crc_r[15] ^ shift_r[7];

  // result fields straight from registers, stable while held
  assign out_valid        = (state_r == sfd_pkg::ST_OUT);
  assign out_status       = err_r ? sfd_pkg::STATUS_REJECT : sfd_pkg::STATUS_DATA;
  assign out_message_id   = msg_id_r;
  assign out_payload_byte = err_r ? 8'd0 : rd_data_r;
  assign out_byte_index   = err_r ? 6'd0 : 6'(rd_idx_r);
  assign out_last         = err_r || (rd_idx_r == IDX_LAST);

  always_comb begin
    state_nxt   = state_r;
    pos_nxt     = pos_r;
    msg_id_nxt  = msg_id_r;
    crc_nxt     = crc_r;
    bit_cnt_nxt = bit_cnt_r;
    rd_idx_nxt  = rd_idx_r;
    err_nxt     = err_r;
    shift_nxt   = shift_r;
    crc_lo_nxt  = crc_lo_r;
    crc_hi_nxt  = crc_hi_r;

    case (state_r)
      sfd_pkg::ST_IDLE: begin
        if (in_fire) begin
          if (pos_r == P_SYNC1) begin
            if (in_rx_byte == sfd_pkg::SYNC_FIRST) begin
              pos_nxt = P_SYNC2;
            end
          end else if (pos_r == P_SYNC2) begin
            // a repeated first sync byte keeps the hunt one step in
            if (in_rx_byte == sfd_pkg::SYNC_SECOND) begin
              pos_nxt = P_MSG_ID;
            end else if (in_rx_byte == sfd_pkg::SYNC_FIRST) begin
              pos_nxt = P_SYNC2;
            end else begin
              pos_nxt = P_SYNC1;
            end
          end else if (pos_r == P_MSG_ID) begin
            msg_id_nxt = in_rx_byte;
            pos_nxt    = P_LENGTH;
          end else if (pos_r == P_LENGTH) begin
            if (in_rx_byte != LEN_BYTE) begin
              pos_nxt   = P_SYNC1;
              err_nxt   = 1'b1;
              state_nxt = sfd_pkg::ST_OUT;
            end else begin
              crc_nxt = sfd_pkg::CRC_INIT;
              pos_nxt = P_PAYLOAD;
            end
          end else if (pos_r < P_TAIL) begin
            pos_nxt = pos_r + P_ONE;
            if (data_pos < P_DATA) begin
              shift_nxt   = in_rx_byte;
              bit_cnt_nxt = 3'd0;
              state_nxt   = sfd_pkg::ST_CRC;
            end else if (data_pos == P_DATA) begin
              crc_lo_nxt = in_rx_byte;
            end else if (data_pos == P_CRC_HI) begin
              crc_hi_nxt = in_rx_byte;
            end
          end else begin
            // tail byte: a bad tail and a crc mismatch give the same reject result
            pos_nxt = P_SYNC1;
            if (in_rx_byte != sfd_pkg::TAIL_BYTE || {crc_hi_r, crc_lo_r} != crc_r) begin
              err_nxt   = 1'b1;
              state_nxt = sfd_pkg::ST_OUT;
            end else begin
              err_nxt    = 1'b0;
              rd_idx_nxt = '0;
              state_nxt  = sfd_pkg::ST_READ;
            end
          end
        end
      end
      sfd_pkg::ST_CRC: begin
        // one message bit per cycle, msb first
        crc_nxt     = {crc_r[14:0], 1'b0} ^ (crc_fb ? sfd_pkg::CRC_POLY : 16'h0000);
        shift_nxt   = {shift_r[6:0], 1'b0};
        bit_cnt_nxt = bit_cnt_r + 3'd1;
        if (bit_cnt_r == 3'd7) begin
          state_nxt = sfd_pkg::ST_IDLE;
        end
      end
      sfd_pkg::ST_READ: begin
        state_nxt = sfd_pkg::ST_OUT;
      end
      sfd_pkg::ST_OUT: begin
        if (out_fire) begin
          if (out_last) begin
            err_nxt   = 1'b0;
            state_nxt = sfd_pkg::ST_IDLE;
          end else begin
            rd_idx_nxt = rd_idx_r + IDX_ONE;
            state_nxt  = sfd_pkg::ST_READ;
          end
        end
      end
      default: begin
        state_nxt = sfd_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= sfd_pkg::ST_IDLE;
      pos_r     <= P_SYNC1;
      msg_id_r  <= 8'd0;
      crc_r     <= sfd_pkg::CRC_INIT;
      bit_cnt_r <= 3'd0;
      rd_idx_r  <= '0;
      err_r     <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      pos_r     <= pos_nxt;
      msg_id_r  <= msg_id_nxt;
      crc_r     <= crc_nxt;
      bit_cnt_r <= bit_cnt_nxt;
      rd_idx_r  <= rd_idx_nxt;
      err_r     <= err_nxt;
    end
  end

  always_ff @(posedge clk) begin
    shift_r  <= shift_nxt;
    crc_lo_r <= crc_lo_nxt;
    crc_hi_r <= crc_hi_nxt;
  end

  // payload memory: write on a data byte transaction, registered read
  always_ff @(posedge clk) begin
    if (in_fire && pos_r >= P_PAYLOAD && pos_r < P_TAIL && data_pos < P_DATA) begin
      payload_mem[data_pos[IDX_W-1:0]] <= in_rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= payload_mem[rd_idx_r];
  end

endmodule
